FILE: rtl/core/rm_pkg.sv
// ----------------------------------------------------------------------------
// rm_pkg
// Shared types, constants and the quarter-wave sine generator of the ring
// modulator.
// ----------------------------------------------------------------------------
package rm_pkg;

  localparam int SAMPLE_WIDTH    = 24;
  localparam int CHANNEL_COUNT   = 2;
  localparam int PHASE_WIDTH     = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int STEP_WIDTH      = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CARRIER_WIDTH   = 16;
  localparam int MAG_WIDTH       = 15;
  localparam int CFG_ADDR_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  // register index carried by paddr[2]
  localparam logic REG_PHASE_STEP = 1'b0;

  localparam logic [MAG_WIDTH-1:0] SINE_FULL = 15'h7FFF;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_product;
    logic signed [SAMPLE_WIDTH-1:0] right_product;
  } out_word_t;

  // how the back end turns a table word into the carrier
  typedef struct packed {
    logic full;   // quadrant edge: use full scale instead of the table
    logic neg;    // lower half turn: negate
  } carrier_ctl_t;

  // sin(pi/2 * k / 2^tbits) in unsigned Q0.15, Taylor series in Q2.30 (elaboration only)
  function automatic logic [MAG_WIDTH-1:0] quarter_sine(input int unsigned k,
                                                        input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'd1686629713 * 64'(k)) >> tbits;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
    t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/core/ring_modulator.sv
// ----------------------------------------------------------------------------
// ring_modulator
// Stereo ring modulator: both channels times a sine carrier from a phase
// accumulator and a quarter-wave table, rounded and saturated to Q1.23.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   rm_pkg::in_word_t
//   out_     output     out_valid/out_ready rm_pkg::out_word_t
//   cfg_     input      APB, pready high    phase_step at address 0
//
// One word per cycle sustained while out_ready stays high; an accepted word
// passes the queue, then the table read, multiply and round/saturate registers.
// The four-entry queue takes words while the back end is held by out_ready,
// so in_ready drops only once the queue is full.
// rst_n is synchronous: it clears phase, phase_step and all valid flags.
// ----------------------------------------------------------------------------
module ring_modulator #(
  parameter int PHASE_WIDTH     = rm_pkg::PHASE_WIDTH,
  parameter int SINE_TABLE_BITS = rm_pkg::SINE_TABLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rm_pkg::in_word_t                  in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rm_pkg::out_word_t                 out_word,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rm_pkg::CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  logic [rm_pkg::CFG_DATA_WIDTH-1:0] cfg_pwdata,
  output logic [rm_pkg::CFG_DATA_WIDTH-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  localparam int QW = $bits(rm_pkg::in_word_t) + SINE_TABLE_BITS +
                      $bits(rm_pkg::carrier_ctl_t);

  logic                       accept;
  logic [SINE_TABLE_BITS-1:0] f_addr;
  rm_pkg::carrier_ctl_t       f_ctl;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  logic [QW-1:0]              q_out;
  rm_pkg::in_word_t           q_word;
  logic [SINE_TABLE_BITS-1:0] q_addr;
  rm_pkg::carrier_ctl_t       q_ctl;

  assign cfg_pready = 1'b1;
  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;

  rm_front #(
    .PHASE_WIDTH    (PHASE_WIDTH),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .accept     (accept),
    .rom_addr   (f_addr),
    .ctl        (f_ctl)
  );

  rm_queue #(
    .WIDTH(QW),
    .DEPTH(rm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data({in_word, f_addr, f_ctl}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  assign {q_word, q_addr, q_ctl} = q_out;

  rm_back #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_word   (q_word),
    .q_addr   (q_addr),
    .q_ctl    (q_ctl),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule

FILE: rtl/core/rm_front.sv
// ----------------------------------------------------------------------------
// rm_front
// Register port, phase accumulator and carrier classification. Each accepted
// word leaves with its table address and carrier control.
// ----------------------------------------------------------------------------
module rm_front #(
  parameter int PHASE_WIDTH     = rm_pkg::PHASE_WIDTH,
  parameter int SINE_TABLE_BITS = rm_pkg::SINE_TABLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rm_pkg::CFG_ADDR_WIDTH-1:0]   cfg_paddr,
  input  logic [rm_pkg::CFG_DATA_WIDTH-1:0]   cfg_pwdata,
  output logic [rm_pkg::CFG_DATA_WIDTH-1:0]   cfg_prdata,
  input  logic                                accept,
  output logic [SINE_TABLE_BITS-1:0]          rom_addr,
  output rm_pkg::carrier_ctl_t                ctl
);

  logic [rm_pkg::STEP_WIDTH-1:0] step_r;
  logic [rm_pkg::STEP_WIDTH-1:0] step_nxt;
  logic [PHASE_WIDTH-1:0]        phase_r;
  logic [PHASE_WIDTH-1:0]        phase_nxt;
  logic [SINE_TABLE_BITS-1:0]    idx;
  logic [1:0]                    quad;
  logic                          wr_en;

  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == rm_pkg::REG_PHASE_STEP);

  always_comb begin
    step_nxt = wr_en ? cfg_pwdata : step_r;
    phase_nxt = accept ? phase_r + PHASE_WIDTH'(step_r) : phase_r;
  end

  always_comb begin
    case (cfg_paddr[2])
      rm_pkg::REG_PHASE_STEP: cfg_prdata = step_r;
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      phase_r <= '0;
    end else begin
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
    end
  end

  // odd quadrants read the table mirrored; index zero there is full scale
  assign quad = phase_r[PHASE_WIDTH-1 -: 2];
  assign idx  = phase_r[PHASE_WIDTH-3 -: SINE_TABLE_BITS];

  always_comb begin
    ctl.neg  = quad[1];
    ctl.full = quad[0] && (idx == '0);
    rom_addr = quad[0] ? SINE_TABLE_BITS'('0) - idx : idx;
  end

endmodule

FILE: rtl/core/rm_queue.sv
// ----------------------------------------------------------------------------
// rm_queue
// Small register FIFO between front and back end.
// ----------------------------------------------------------------------------
module rm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r;
  logic [PW-1:0]    wr_nxt;
  logic [PW-1:0]    rd_r;
  logic [PW-1:0]    rd_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/rm_back.sv
// ----------------------------------------------------------------------------
// rm_back
// Sine table read, carrier multiply and round/saturate, three stages that
// advance together whenever the output register can move.
// ----------------------------------------------------------------------------
module rm_back #(
  parameter int SINE_TABLE_BITS = rm_pkg::SINE_TABLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  rm_pkg::in_word_t            q_word,
  input  logic [SINE_TABLE_BITS-1:0]  q_addr,
  input  rm_pkg::carrier_ctl_t        q_ctl,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rm_pkg::out_word_t           out_word
);

  localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int SW         = rm_pkg::SAMPLE_WIDTH;
  localparam int CW         = rm_pkg::CARRIER_WIDTH;
  localparam int PRW        = SW + CW;
  localparam int NCH        = rm_pkg::CHANNEL_COUNT;
  localparam logic signed [SW:0] SAT_HI = (SW+1)'((1 << (SW - 1)) - 1);
  localparam logic signed [SW:0] SAT_LO = -(SW+1)'(1 << (SW - 1));

  logic [rm_pkg::MAG_WIDTH-1:0] rom [TABLE_SIZE];

  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
    localparam logic [rm_pkg::MAG_WIDTH-1:0] ENTRY =
      rm_pkg::quarter_sine(k, SINE_TABLE_BITS);
    assign rom[k] = ENTRY;
  end

  logic                          en;
  // stage 1: table word
  logic                          v1_r;
  logic [rm_pkg::MAG_WIDTH-1:0]  mag1_r;
  rm_pkg::carrier_ctl_t          ctl1_r;
  logic signed [SW-1:0]          smp1_r [NCH];
  // stage 2: products
  logic                          v2_r;
  logic signed [PRW-1:0]         prod2_r [NCH];
  // stage 3: output register
  logic                          v3_r;
  logic signed [SW-1:0]          res3_r [NCH];

  logic [rm_pkg::MAG_WIDTH-1:0]  mag;
  logic signed [CW-1:0]          carrier;
  logic signed [SW-1:0]          smp_in [NCH];
  logic signed [PRW-1:0]         rnd [NCH];
  logic signed [SW:0]            shr [NCH];
  logic signed [SW-1:0]          sat [NCH];

  assign en    = !v3_r || out_ready;
  assign q_pop = en && !q_empty;

  assign smp_in[0] = q_word.left_sample;
  assign smp_in[1] = q_word.right_sample;

  always_comb begin
    mag     = ctl1_r.full ? rm_pkg::SINE_FULL : mag1_r;
    carrier = ctl1_r.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // round half up, then clamp to the sample range
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      rnd[c] = prod2_r[c] + PRW'(1 << 14);
      shr[c] = rnd[c][PRW-1 -: SW+1];
      if (shr[c] > SAT_HI) begin
        sat[c] = SAT_HI[SW-1:0];
      end else if (shr[c] < SAT_LO) begin
        sat[c] = SAT_LO[SW-1:0];
      end else begin
        sat[c] = shr[c][SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= rom[q_addr];
      ctl1_r <= q_ctl;
      for (int c = 0; c < NCH; c++) begin
        smp1_r[c]  <= smp_in[c];
        prod2_r[c] <= PRW'(smp1_r[c]) * PRW'(carrier);
        res3_r[c]  <= sat[c];
      end
    end
  end

  assign out_valid              = v3_r;
  assign out_word.left_product  = res3_r[0];
  assign out_word.right_product = res3_r[1];

endmodule

FILE: rtl/core/rm_checker.sv
// ----------------------------------------------------------------------------
// rm_checker
// Port-level checks on the ring modulator: word accounting, reset and
// output hold.
// ----------------------------------------------------------------------------
module rm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rm_pkg::out_word_t out_word
);

  // queue plus three back-end stages
  localparam int CAPACITY = rm_pkg::QUEUE_DEPTH + 3;

  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({in_valid && in_ready, out_valid && out_ready})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // no word out that was not taken in
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("output word without a pending input word");

  // in flight never exceeds what the pipeline can hold
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'(CAPACITY))
    else $error("more words in flight than storage");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

endmodule

bind ring_modulator rm_checker u_rm_checker (.*);
